FILE: design/bda_pkg.sv
// shared types, widths and the brightness-to-alpha curve
package bda_pkg;

    localparam int BRIGHT_W          = 12;
    localparam int ALPHA_W           = 8;
    localparam int SRC_W             = 2;
    localparam int DEFINED_POINTS    = 20;
    localparam int TABLE_ENTRIES_DEF = 20;
    localparam int LOW_LIMIT         = 3;
    localparam int ALPHA_MAX         = 255;

    // divider: magnitudes only, two quotient bits per cycle
    localparam int Q_W       = 26;
    localparam int DVSR_W    = BRIGHT_W;
    localparam int DIV_STEPS = Q_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [BRIGHT_W-1:0] CURVE_LVL [DEFINED_POINTS] = '{
        12'd0,   12'd1,   12'd2,   12'd3,   12'd4,
        12'd6,   12'd10,  12'd20,  12'd30,  12'd45,
        12'd70,  12'd100, 12'd150, 12'd227, 12'd300,
        12'd400, 12'd500, 12'd600, 12'd800, 12'd1023
    };

    localparam logic [ALPHA_W-1:0] CURVE_VAL [DEFINED_POINTS] = '{
        8'hff, 8'hee, 8'he8, 8'he6, 8'he5,
        8'he4, 8'he0, 8'hd5, 8'hce, 8'hc6,
        8'hb7, 8'had, 8'ha0, 8'h8a, 8'h80,
        8'h6e, 8'h5b, 8'h50, 8'h38, 8'h18
    };

    typedef enum logic [SRC_W-1:0] {
        SRC_OVERRIDE = SRC_W'(0),
        SRC_HELD     = SRC_W'(1),
        SRC_TABLE    = SRC_W'(2)
    } src_t;

    typedef enum logic [1:0] {
        PATH_OVERRIDE,
        PATH_HOLD,
        PATH_END,
        PATH_BLEND
    } path_t;

    typedef enum logic {
        DSEL_DX,
        DSEL_DY
    } dsel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASSIFY,
        S_MUL1,
        S_DIV1_GO,
        S_DIV1,
        S_MUL2,
        S_DIV2_GO,
        S_DIV2,
        S_DIV3_GO,
        S_DIV3,
        S_SUM,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic  load;
        logic  seg;
        logic  mul1;
        logic  mul2;
        logic  div_start;
        dsel_t div_sel;
        logic  take_twice;
        logic  take_q2;
        logic  take_corr;
        logic  sum;
        logic  write;
    } cmd_t;

    typedef struct packed {
        path_t path;
        logic  dy_zero;
        logic  div_done;
    } status_t;

endpackage

FILE: design/bda_div.sv
// serial unsigned divider, two quotient bits per cycle
module bda_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bda_pkg::Q_W-1:0]    dividend,
    input  logic [bda_pkg::DVSR_W-1:0] divisor,
    output logic [bda_pkg::Q_W-1:0]    quotient,
    output logic                     done
);
    import bda_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DVSR_W-1:0]   rem_reg;
    logic [Q_W-1:0]      quo_reg;
    logic [DVSR_W-1:0]   dvsr_reg;
    logic [DVSR_W-1:0]   rem_next;
    logic [Q_W-1:0]      quo_next;

    always_comb
    begin
        logic [DVSR_W:0] t;
        logic [DVSR_W-1:0] r;
        logic [Q_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        t = '0;
        for (int k = 0; k < 2; k++)
        begin
            t = {r, q[Q_W-1]};
            q = {q[Q_W-2:0], 1'b0};
            if (t >= {1'b0, dvsr_reg})
            begin
                t    = t - {1'b0, dvsr_reg};
                q[0] = 1'b1;
            end
            r = t[DVSR_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

FILE: design/bda_dp.sv
// datapath: curve search, products, shared divider, rounding and saturation
module bda_dp #(
    parameter int TABLE_ENTRIES = bda_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bda_pkg::BRIGHT_W-1:0] brightness,
    input  logic                         cfg_we,
    input  logic [bda_pkg::ALPHA_W-1:0]  cfg_wdata,
    input  bda_pkg::cmd_t                cmd,
    output bda_pkg::status_t             st,
    output logic [bda_pkg::ALPHA_W-1:0]  alpha,
    output logic [bda_pkg::SRC_W-1:0]    alpha_source
);
    import bda_pkg::*;

    localparam int N_PTS = (TABLE_ENTRIES < DEFINED_POINTS) ? TABLE_ENTRIES : DEFINED_POINTS;
    localparam int P1_W  = ALPHA_W + BRIGHT_W;
    localparam int P2_W  = 2 * BRIGHT_W;
    localparam int SUM_W = Q_W + 2;

    logic [ALPHA_W-1:0]  override_reg;
    logic [ALPHA_W-1:0]  held_alpha_reg;
    logic [BRIGHT_W-1:0] bright_reg;

    logic [ALPHA_W-1:0]  ya_reg;
    logic [ALPHA_W-1:0]  dy_mag_reg;
    logic                dy_neg_reg;
    logic [BRIGHT_W-1:0] dxa_reg;
    logic [BRIGHT_W-1:0] dxb_reg;
    logic [BRIGHT_W-1:0] dx_reg;
    logic [Q_W-1:0]      num_reg;
    logic                num_neg_reg;
    logic [Q_W-1:0]      tw_mag_reg;
    logic                tw_neg_reg;
    logic [Q_W-1:0]      corr_mag_reg;
    logic                corr_neg_reg;
    logic [ALPHA_W-1:0]  res_alpha_reg;
    src_t                res_src_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    src_t                alpha_source_reg;

    path_t               path_c;
    logic [BRIGHT_W-1:0] xa_c;
    logic [BRIGHT_W-1:0] xb_c;
    logic [ALPHA_W-1:0]  ya_c;
    logic [ALPHA_W-1:0]  yb_c;
    logic [ALPHA_W-1:0]  end_alpha_c;

    logic [P1_W-1:0]     p1;
    logic [P2_W-1:0]     p2;
    logic [DVSR_W-1:0]   divisor_c;
    logic [Q_W-1:0]      quotient;
    logic                div_done;
    logic [Q_W:0]        rnd_c;
    logic [ALPHA_W-1:0]  sat_c;

    // first curve point at or above the brightness
    always_comb
    begin
        logic found;
        logic first_hit;
        found       = 1'b0;
        first_hit   = 1'b0;
        xa_c        = '0;
        xb_c        = '0;
        ya_c        = '0;
        yb_c        = '0;
        for (int i = 0; i < N_PTS; i++)
        begin
            if (!found && CURVE_LVL[i] >= bright_reg)
            begin
                found = 1'b1;
                if (i == 0)
                begin
                    first_hit = 1'b1;
                end
                else
                begin
                    xa_c = CURVE_LVL[(i > 0) ? i - 1 : 0];
                    ya_c = CURVE_VAL[(i > 0) ? i - 1 : 0];
                    xb_c = CURVE_LVL[i];
                    yb_c = CURVE_VAL[i];
                end
            end
        end
        end_alpha_c = first_hit ? CURVE_VAL[0] : CURVE_VAL[N_PTS-1];
        if (override_reg != '0)
            path_c = PATH_OVERRIDE;
        else if (bright_reg <= BRIGHT_W'(LOW_LIMIT))
            path_c = PATH_HOLD;
        else if (!found || first_hit)
            path_c = PATH_END;
        else
            path_c = PATH_BLEND;
    end

    assign p1 = dy_mag_reg * dxa_reg;
    assign p2 = dxa_reg * dxb_reg;
    assign divisor_c = (cmd.div_sel == DSEL_DY) ?
                       {{(DVSR_W-ALPHA_W){1'b0}}, dy_mag_reg} : dx_reg;

    // halves away from zero: magnitude (q + 1) / 2
    assign rnd_c = {1'b0, quotient} + (Q_W+1)'(1);

    always_comb
    begin
        logic signed [SUM_W-1:0] ya_s;
        logic signed [SUM_W-1:0] tw_s;
        logic signed [SUM_W-1:0] corr_s;
        logic signed [SUM_W-1:0] sum_s;
        ya_s   = $signed({{(SUM_W-ALPHA_W){1'b0}}, ya_reg});
        tw_s   = $signed({2'b00, tw_mag_reg});
        corr_s = $signed({2'b00, corr_mag_reg});
        if (tw_neg_reg)
            tw_s = -tw_s;
        if (corr_neg_reg)
            corr_s = -corr_s;
        sum_s = ya_s + tw_s + corr_s;
        if (sum_s < 0)
            sat_c = '0;
        else if (sum_s > $signed(SUM_W'(ALPHA_MAX)))
            sat_c = ALPHA_W'(ALPHA_MAX);
        else
            sat_c = sum_s[ALPHA_W-1:0];
    end

    bda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (divisor_c),
        .quotient (quotient),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            override_reg   <= '0;
            held_alpha_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                override_reg <= cfg_wdata;
            if (cmd.write && res_src_reg == SRC_TABLE)
                held_alpha_reg <= res_alpha_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            bright_reg <= brightness;

        if (cmd.seg)
        begin
            ya_reg       <= ya_c;
            dy_neg_reg   <= (yb_c < ya_c);
            dy_mag_reg   <= (yb_c < ya_c) ? (ya_c - yb_c) : (yb_c - ya_c);
            dxa_reg      <= bright_reg - xa_c;
            dxb_reg      <= xb_c - bright_reg;
            dx_reg       <= xb_c - xa_c;
            corr_mag_reg <= '0;
            corr_neg_reg <= 1'b0;
            unique case (path_c)
                PATH_OVERRIDE:
                begin
                    res_alpha_reg <= override_reg;
                    res_src_reg   <= SRC_OVERRIDE;
                end
                PATH_HOLD:
                begin
                    res_alpha_reg <= held_alpha_reg;
                    res_src_reg   <= SRC_HELD;
                end
                PATH_END:
                begin
                    res_alpha_reg <= end_alpha_c;
                    res_src_reg   <= SRC_TABLE;
                end
                PATH_BLEND:
                begin
                    res_src_reg <= SRC_TABLE;
                end
                default:
                begin
                    res_src_reg <= SRC_TABLE;
                end
            endcase
        end

        // 2*dy*(x-xa), sign from dy
        if (cmd.mul1)
        begin
            num_reg     <= {{(Q_W-P1_W-1){1'b0}}, p1, 1'b0};
            num_neg_reg <= dy_neg_reg;
        end

        // 2*(x-xa)*(x-xb) is never positive
        if (cmd.mul2)
        begin
            num_reg     <= {{(Q_W-P2_W-1){1'b0}}, p2, 1'b0};
            num_neg_reg <= 1'b1;
        end

        if (cmd.take_twice)
        begin
            tw_mag_reg <= rnd_c[Q_W:1];
            tw_neg_reg <= num_neg_reg;
        end

        if (cmd.take_q2)
        begin
            num_reg     <= quotient;
            num_neg_reg <= num_neg_reg ^ dy_neg_reg;
        end

        // divisor xa - xb is negative
        if (cmd.take_corr)
        begin
            corr_mag_reg <= quotient;
            corr_neg_reg <= ~num_neg_reg;
        end

        if (cmd.sum)
            res_alpha_reg <= sat_c;

        if (cmd.write)
        begin
            alpha_reg        <= res_alpha_reg;
            alpha_source_reg <= res_src_reg;
        end
    end

    assign st.path     = path_c;
    assign st.dy_zero  = (dy_mag_reg == '0);
    assign st.div_done = div_done;

    assign alpha        = alpha_reg;
    assign alpha_source = alpha_source_reg;

`ifndef ASSERT_OFF
    a_seg_width: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.seg && path_c == PATH_BLEND) |=> (dx_reg != '0))
        else $error("interpolation segment with zero width");
`endif

endmodule

FILE: design/bda_ctrl.sv
// controller: sequences one item through search, divisions and result write
module bda_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bda_pkg::status_t st,
    output bda_pkg::cmd_t    cmd
);
    import bda_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CLASSIFY;
            S_CLASSIFY:
                state_next = (st.path == PATH_BLEND) ? S_MUL1 : S_WRITE;
            S_MUL1:
                state_next = S_DIV1_GO;
            S_DIV1_GO:
                state_next = S_DIV1;
            S_DIV1:
                if (st.div_done)
                    state_next = st.dy_zero ? S_SUM : S_MUL2;
            S_MUL2:
                state_next = S_DIV2_GO;
            S_DIV2_GO:
                state_next = S_DIV2;
            S_DIV2:
                if (st.div_done)
                    state_next = S_DIV3_GO;
            S_DIV3_GO:
                state_next = S_DIV3;
            S_DIV3:
                if (st.div_done)
                    state_next = S_SUM;
            S_SUM:
                state_next = S_WRITE;
            S_WRITE:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DSEL_DX;
        unique case (state_reg)
            S_IDLE:     cmd.load = in_valid;
            S_CLASSIFY: cmd.seg = 1'b1;
            S_MUL1:     cmd.mul1 = 1'b1;
            S_DIV1_GO:  cmd.div_start = 1'b1;
            S_DIV1:     cmd.take_twice = st.div_done;
            S_MUL2:     cmd.mul2 = 1'b1;
            S_DIV2_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_DY;
            end
            S_DIV2:
            begin
                cmd.div_sel = DSEL_DY;
                cmd.take_q2 = st.div_done;
            end
            S_DIV3_GO:  cmd.div_start = 1'b1;
            S_DIV3:     cmd.take_corr = st.div_done;
            S_SUM:      cmd.sum = 1'b1;
            S_WRITE:    cmd.write = slot_free;
            default:    cmd.load = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cmd.write)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!out_valid_reg || out_ready))
        else $error("result written over an item not yet taken");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> (state_reg == S_DIV1 || state_reg == S_DIV2 || state_reg == S_DIV3))
        else $error("quotient arrived outside a wait state");

    a_accept_classify: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CLASSIFY))
        else $error("accepted item not classified next");
`endif

endmodule

FILE: design/brightness_to_dim_alpha.sv
// top level: backlight brightness to dim-layer alpha
// override, low brightness and curve end pass from accept through classify to write;
// a flat segment takes one division, a full interpolation three serial divisions
// one item at a time: a new item is accepted only in idle, after the write of the last,
// which waits for a free output slot; one shared divider, two quotient bits per cycle
// reset: override register and held alpha clear to 0, no item in flight
module brightness_to_dim_alpha #(
    parameter int TABLE_ENTRIES = bda_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bda_pkg::BRIGHT_W-1:0] brightness,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bda_pkg::ALPHA_W-1:0]  alpha,
    output logic [bda_pkg::SRC_W-1:0]    alpha_source,
    input  logic                         cfg_we,
    input  logic [bda_pkg::ALPHA_W-1:0]  cfg_wdata
);
    import bda_pkg::*;

    cmd_t    cmd;
    status_t st;

    bda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    bda_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .brightness   (brightness),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .st           (st),
        .alpha        (alpha),
        .alpha_source (alpha_source)
    );

endmodule
